FILE: rtl/s256_pkg.sv
// ----------------------------------------------------------------------------
// s256_pkg
// Shared types, constants and round functions for the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package s256_pkg;

    localparam int BLOCK_BITS = 512;
    localparam int WORD_BITS  = 32;
    localparam int HASH_WORDS = 8;
    localparam int SCHED_WORDS = 16;
    localparam int LEN_BITS   = 64;
    localparam int MSG_BITS   = 61;

    localparam logic [5:0] LAST_SLOT  = 6'd63;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [7:0] PAD_BYTE   = 8'h80;

    // request codes
    localparam logic REQ_DATA   = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    typedef logic [HASH_WORDS-1:0][WORD_BITS-1:0]  hash_t;
    typedef logic [SCHED_WORDS-1:0][WORD_BITS-1:0] sched_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_COMP,
        ST_EMIT
    } s256_state_t;

    // initial hash values, word 0 at index 0
    localparam hash_t H_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    // round constants
    function automatic logic [31:0] round_k(input logic [5:0] idx);
        case (idx)
            6'd0:  round_k = 32'h428a2f98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;
            6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;
            6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;
            6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;
            6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;
            6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;
            6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;
            6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;
            6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;
            6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;
            6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;
            6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;
            6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;
            6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;
            6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;
            6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;
            6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;
            6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;
            6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;
            6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;
            6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;
            6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;
            6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;
            6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;
            6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;
            6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;
            6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;
            6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;
            6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;
            6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            6'd63: round_k = 32'hc67178f2;
            default: round_k = '0;
        endcase
    endfunction

endpackage

FILE: rtl/s256_req_if.sv
// ----------------------------------------------------------------------------
// s256_req_if
// Request channel: one beat appends a byte or finishes the message.
// ----------------------------------------------------------------------------
interface s256_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

FILE: rtl/s256_dig_if.sv
// ----------------------------------------------------------------------------
// s256_dig_if
// Digest channel: one beat carries the 256-bit digest in four parts.
// ----------------------------------------------------------------------------
interface s256_dig_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_part0;
    logic [63:0] digest_part1;
    logic [63:0] digest_part2;
    logic [63:0] digest_part3;

    modport source (output valid, output digest_part0, output digest_part1,
                    output digest_part2, output digest_part3, input ready);
    modport sink   (input valid, input digest_part0, input digest_part1,
                    input digest_part2, input digest_part3, output ready);
endinterface

FILE: rtl/s256_round_core.sv
// ----------------------------------------------------------------------------
// s256_round_core
// Iterative compression: one round per cycle, with a sliding
// 16-word message schedule window.
// ----------------------------------------------------------------------------
module s256_round_core
    import s256_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [BLOCK_BITS-1:0] block,
    input  hash_t                 hash_in,
    output logic                  busy,
    output logic                  done,
    output hash_t                 v_out
);

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [5:0] round_reg, round_next;
    hash_t      v_reg, v_next;
    sched_t     w_reg, w_next;

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] w_new;

    // round datapath and schedule expansion
    always_comb
    begin
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1    = v_reg[7] + big_sigma1(v_reg[4]) + ch + round_k(round_reg) + w_reg[0];
        t2    = big_sigma0(v_reg[0]) + maj;
        w_new = w_reg[0] + small_sigma0(w_reg[1]) + w_reg[9] + small_sigma1(w_reg[14]);
    end

    // sequencer
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        round_next = round_reg;
        v_next     = v_reg;
        w_next     = w_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            round_next = '0;
            v_next     = hash_in;
            for (int j = 0; j < SCHED_WORDS; j++)
            begin
                w_next[j] = block[BLOCK_BITS-1-WORD_BITS*j -: WORD_BITS];
            end
        end
        else if (busy_reg)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
            for (int j = 0; j < SCHED_WORDS - 1; j++)
            begin
                w_next[j] = w_reg[j+1];
            end
            w_next[SCHED_WORDS-1] = w_new;
            round_next = round_reg + 6'd1;
            if (round_reg == LAST_SLOT)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            round_reg <= round_next;
        end
    end

    // working variables and schedule window
    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        w_reg <= w_next;
    end

    assign busy  = busy_reg;
    assign done  = done_reg;
    assign v_out = v_reg;

endmodule

FILE: rtl/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, one byte per request beat, digest on finish.
// Ready: the byte that fills a block holds ready low while the block is loaded
// into the round core, its 64 rounds run and the hash is updated.
// New bytes are taken only while no block is being padded or compressed.
// Finish: pad and length bytes shift in at one per cycle, then one or two
// compressions follow; the digest then sits in an output register.
// Reset: rst_n clears control and loads the initial hash values.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher
    import s256_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    s256_req_if.sink     req,
    s256_dig_if.source   dig
);

    s256_state_t state_reg, state_next;

    logic [BLOCK_BITS-1:0] blk_reg, blk_next;
    logic [5:0]            fill_reg, fill_next;
    logic [MSG_BITS-1:0]   msg_reg, msg_next;
    logic [LEN_BITS-1:0]   len_reg, len_next;
    hash_t                 hash_reg, hash_next;
    logic                  fin_reg, fin_next;
    logic                  len_ok_reg, len_ok_next;
    logic                  len_done_reg, len_done_next;

    logic                  out_valid_reg, out_valid_next;
    logic [63:0]           out0_reg, out0_next;
    logic [63:0]           out1_reg, out1_next;
    logic [63:0]           out2_reg, out2_next;
    logic [63:0]           out3_reg, out3_next;

    logic                  req_beat;
    logic                  core_start;
    logic                  core_busy;
    logic                  core_done;
    hash_t                 core_v;
    logic                  len_slot;
    logic [7:0]            pad_byte;

    s256_round_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (core_start),
        .block   (blk_reg),
        .hash_in (hash_reg),
        .busy    (core_busy),
        .done    (core_done),
        .v_out   (core_v)
    );

    assign req.ready  = (state_reg == ST_IDLE);
    assign req_beat   = req.valid && req.ready;
    assign core_start = (state_reg == ST_LOAD);

    // length bytes go into the last eight slots of the final block
    assign len_slot = len_ok_reg && (fill_reg >= LEN_OFFSET);
    assign pad_byte = len_slot ? len_reg[LEN_BITS-1 -: 8] : 8'h00;

    // next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        blk_next       = blk_reg;
        fill_next      = fill_reg;
        msg_next       = msg_reg;
        len_next       = len_reg;
        hash_next      = hash_reg;
        fin_next       = fin_reg;
        len_ok_next    = len_ok_reg;
        len_done_next  = len_done_reg;
        out_valid_next = out_valid_reg;
        out0_next      = out0_reg;
        out1_next      = out1_reg;
        out2_next      = out2_reg;
        out3_next      = out3_reg;

        if (out_valid_reg && dig.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_beat)
                begin
                    fill_next = fill_reg + 6'd1;
                    if (req.req_type == REQ_DATA)
                    begin
                        blk_next = {blk_reg[BLOCK_BITS-9:0], req.data_byte};
                        msg_next = msg_reg + 61'd1;
                    end
                    else
                    begin
                        blk_next      = {blk_reg[BLOCK_BITS-9:0], PAD_BYTE};
                        len_next      = {msg_reg, 3'b000};
                        fin_next      = 1'b1;
                        len_ok_next   = (fill_reg < LEN_OFFSET);
                        len_done_next = 1'b0;
                    end
                    if (fill_reg == LAST_SLOT)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (req.req_type == REQ_FINISH)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end

            // zero fill and length, one byte per cycle
            ST_PAD:
            begin
                blk_next  = {blk_reg[BLOCK_BITS-9:0], pad_byte};
                fill_next = fill_reg + 6'd1;
                if (len_slot)
                begin
                    len_next = {len_reg[LEN_BITS-9:0], 8'h00};
                end
                if (fill_reg == LAST_SLOT)
                begin
                    state_next = ST_LOAD;
                    if (len_ok_reg)
                    begin
                        len_done_next = 1'b1;
                    end
                end
            end

            ST_LOAD:
            begin
                state_next = ST_COMP;
            end

            // wait for the rounds, then fold into the hash
            ST_COMP:
            begin
                if (core_done)
                begin
                    for (int j = 0; j < HASH_WORDS; j++)
                    begin
                        hash_next[j] = hash_reg[j] + core_v[j];
                    end
                    if (!fin_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (len_done_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        len_ok_next = 1'b1;
                        state_next  = ST_PAD;
                    end
                end
            end

            // hand the digest to the output register and start a new message
            ST_EMIT:
            begin
                if (!out_valid_reg || dig.ready)
                begin
                    out_valid_next = 1'b1;
                    out0_next      = {hash_reg[0], hash_reg[1]};
                    out1_next      = {hash_reg[2], hash_reg[3]};
                    out2_next      = {hash_reg[4], hash_reg[5]};
                    out3_next      = {hash_reg[6], hash_reg[7]};
                    hash_next      = H_INIT;
                    fill_next      = '0;
                    msg_next       = '0;
                    fin_next       = 1'b0;
                    len_ok_next    = 1'b0;
                    len_done_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            msg_reg       <= '0;
            hash_reg      <= H_INIT;
            fin_reg       <= 1'b0;
            len_ok_reg    <= 1'b0;
            len_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            msg_reg       <= msg_next;
            hash_reg      <= hash_next;
            fin_reg       <= fin_next;
            len_ok_reg    <= len_ok_next;
            len_done_reg  <= len_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        len_reg  <= len_next;
        out0_reg <= out0_next;
        out1_reg <= out1_next;
        out2_reg <= out2_next;
        out3_reg <= out3_next;
    end

    assign dig.valid        = out_valid_reg;
    assign dig.digest_part0 = out0_reg;
    assign dig.digest_part1 = out1_reg;
    assign dig.digest_part2 = out2_reg;
    assign dig.digest_part3 = out3_reg;

    // the round core only runs while the sequencer waits for it
    a_core_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
        (core_busy || core_done) |-> (state_reg == ST_COMP))
        else $error("round core active outside compress state");

    // a finished digest restarts the message from the initial hash
    a_emit_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && state_next == ST_IDLE)
        |=> (fill_reg == '0 && msg_reg == '0 && hash_reg == H_INIT && out_valid_reg))
        else $error("message state not restarted after digest");

    // a padding block without the length is always followed by one with it
    a_second_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP && core_done && fin_reg && !len_done_reg)
        |=> (state_reg == ST_PAD && fill_reg == '0 && len_ok_reg))
        else $error("missing length block after padding overflow");

endmodule

FILE: bench/tb_sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// tb_sha256_byte_stream_hasher
// Self-checking bench for the SHA-256 byte stream hasher. Request beats carry
// random and fixed bytes and finish beats. A local SHA-256 predictor turns each finish
// into an expected digest, and every digest beat is compared part by part.
// Both channels idle at random outside a steady phase, with one long digest stall and a drain pause.
// ----------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher
    import s256_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_STALL  = 300;
    localparam int QUIET_LIMIT = 4000;
    localparam int END_SETTLE  = 80;
    localparam int RANDOM_BEATS = 1300;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // part i of the digest at index i
    typedef logic [3:0][63:0] digest_t;

    logic clk;
    logic rst_n;

    s256_req_if req_ch ();
    s256_dig_if dig_ch ();

    sha256_byte_stream_hasher uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .dig   (dig_ch)
    );

    // predictor state
    hash_t           chain_hash;
    logic [63:0][7:0] blk_bytes;
    logic [5:0]      blk_fill;
    logic [60:0]     byte_count;   // wraps modulo 2^61 like the block
    digest_t         pending_digests [$];

    // bench control and tallies
    bit steady_flow;
    int stall_order;
    int stall_served;
    int stall_left;
    int quiet_cycles;
    int fail_count;
    int beats_sent;
    int digests_checked;

    // clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of a full block into the chaining value
    function automatic hash_t sha_compress(input hash_t h_in, input logic [63:0][7:0] blk);
        logic [31:0] w [64];
        logic [31:0] va, vb, vc, vd, ve, vf, vg, vh, t1, t2, s0, s1;
        hash_t h_out;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        end
        for (int i = 16; i < 64; i++)
        begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        va = h_in[0]; vb = h_in[1]; vc = h_in[2]; vd = h_in[3];
        ve = h_in[4]; vf = h_in[5]; vg = h_in[6]; vh = h_in[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = vh + (ror32(ve, 6) ^ ror32(ve, 11) ^ ror32(ve, 25))
                 + ((ve & vf) ^ (~ve & vg)) + ROUND_K[i] + w[i];
            t2 = (ror32(va, 2) ^ ror32(va, 13) ^ ror32(va, 22))
                 + ((va & vb) ^ (va & vc) ^ (vb & vc));
            vh = vg; vg = vf; vf = ve; ve = vd + t1;
            vd = vc; vc = vb; vb = va; va = t1 + t2;
        end
        h_out[0] = h_in[0] + va; h_out[1] = h_in[1] + vb;
        h_out[2] = h_in[2] + vc; h_out[3] = h_in[3] + vd;
        h_out[4] = h_in[4] + ve; h_out[5] = h_in[5] + vf;
        h_out[6] = h_in[6] + vg; h_out[7] = h_in[7] + vh;
        return h_out;
    endfunction

    task automatic start_new_message();
        chain_hash = H_INIT;
        blk_fill   = '0;
        byte_count = '0;
    endtask

    // advance the predictor by one accepted request beat
    task automatic absorb_beat(input logic kind, input logic [7:0] b);
        logic [63:0] bit_len;
        digest_t     dg;
        int          idx;
        if (kind == REQ_DATA)
        begin
            blk_bytes[blk_fill] = b;
            blk_fill   = blk_fill + 6'd1;
            byte_count = byte_count + 61'd1;
            if (blk_fill == '0)
                chain_hash = sha_compress(chain_hash, blk_bytes);
        end
        else
        begin
            bit_len = {byte_count, 3'b000};
            idx = int'(blk_fill);
            blk_bytes[idx] = PAD_BYTE;
            idx++;
            // no room for the length: close this block and start another
            if (idx > int'(LEN_OFFSET))
            begin
                while (idx < 64)
                begin
                    blk_bytes[idx] = 8'h00;
                    idx++;
                end
                chain_hash = sha_compress(chain_hash, blk_bytes);
                idx = 0;
            end
            while (idx < int'(LEN_OFFSET))
            begin
                blk_bytes[idx] = 8'h00;
                idx++;
            end
            for (int i = 0; i < 8; i++)
                blk_bytes[int'(LEN_OFFSET) + i] = bit_len[63 - 8*i -: 8];
            chain_hash = sha_compress(chain_hash, blk_bytes);
            for (int i = 0; i < 4; i++)
                dg[i] = {chain_hash[2*i], chain_hash[2*i+1]};
            pending_digests.push_back(dg);
            start_new_message();
        end
    endtask

    // offer one request beat, with random idle cycles ahead of it unless the flow is steady
    task automatic send_beat(input logic kind, input logic [7:0] b);
        if (!steady_flow)
        begin
            while ($urandom_range(99) < 24)
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.data_byte <= b;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        absorb_beat(kind, b);
        beats_sent++;
    endtask

    // random bytes followed by a finish carrying a random ignored byte
    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_beat(REQ_DATA, 8'($urandom_range(255)));
        send_beat(REQ_FINISH, 8'($urandom_range(255)));
    endtask

    task automatic sender_quiet();
        req_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_digests.size() != 0)
            @(posedge clk);
    endtask

    // digest sink: long stall on request, else random or steady ready
    always @(posedge clk)
    begin
        if (stall_order != stall_served)
        begin
            stall_served <= stall_order;
            stall_left   <= LONG_STALL;
            dig_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            dig_ch.ready <= 1'b0;
        end
        else if (steady_flow)
            dig_ch.ready <= 1'b1;
        else
            dig_ch.ready <= ($urandom_range(99) >= 24);
    end

    // digest checker
    always @(posedge clk)
    begin
        digest_t want;
        digest_t got;
        if (dig_ch.valid && dig_ch.ready)
        begin
            got = {dig_ch.digest_part3, dig_ch.digest_part2,
                   dig_ch.digest_part1, dig_ch.digest_part0};
            if (pending_digests.size() == 0)
            begin
                $error("digest beat with no finish pending: %h", got);
                fail_count++;
            end
            else
            begin
                want = pending_digests.pop_front();
                for (int i = 0; i < 4; i++)
                begin
                    if (got[i] !== want[i])
                    begin
                        $error("digest_part%0d: expected %h, actual %h", i, want[i], got[i]);
                        fail_count++;
                    end
                end
                digests_checked++;
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (dig_ch.valid && dig_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout after %0d cycles with no beat", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // empty message, back-to-back finishes, ignored byte at both extremes
    task automatic test_empty_message();
        send_beat(REQ_FINISH, 8'h00);
        send_beat(REQ_FINISH, 8'hFF);
        send_beat(REQ_FINISH, 8'h5A);
    endtask

    // short messages with extreme and known bytes
    task automatic test_short_messages();
        send_beat(REQ_DATA, 8'h61);
        send_beat(REQ_DATA, 8'h62);
        send_beat(REQ_DATA, 8'h63);
        send_beat(REQ_FINISH, 8'h00);
        send_beat(REQ_DATA, 8'h00);
        send_beat(REQ_FINISH, 8'hFF);
        send_beat(REQ_DATA, 8'hFF);
        send_beat(REQ_FINISH, 8'h00);
        send_beat(REQ_DATA, 8'hFF);
        send_beat(REQ_DATA, 8'h00);
        send_beat(REQ_DATA, 8'h80);
        send_beat(REQ_DATA, 8'h01);
        send_beat(REQ_FINISH, 8'h80);
    endtask

    // lengths around the point where padding needs an extra block
    task automatic test_pad_boundaries();
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);
        send_message(120);
    endtask

    // digest side stalls long while requests keep coming, then drain
    task automatic test_back_pressure();
        stall_order <= stall_order + 1;
        for (int m = 0; m < 6; m++)
            send_message($urandom_range(1, 8));
        sender_quiet();
        wait_drained();
    endtask

    // no idling on either side
    task automatic test_steady_stream();
        int start_beats;
        steady_flow = 1'b1;
        start_beats = beats_sent;
        while (beats_sent - start_beats < 150)
            send_message($urandom_range(0, 40));
        steady_flow = 1'b0;
    endtask

    // mostly short messages, some multi-block, some runs of bare finishes
    task automatic test_random_messages();
        int pick;
        while (beats_sent < RANDOM_BEATS)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
            begin
                repeat ($urandom_range(2, 4))
                    send_beat(REQ_FINISH, 8'($urandom_range(255)));
            end
            else if (pick < 15)
                send_message($urandom_range(41, 130));
            else
                send_message($urandom_range(0, 40));
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_DATA;
        req_ch.data_byte = 8'h00;
        dig_ch.ready     = 1'b0;
        steady_flow      = 1'b0;
        stall_order      = 0;
        stall_served     = 0;
        stall_left       = 0;
        quiet_cycles     = 0;
        fail_count       = 0;
        beats_sent       = 0;
        digests_checked  = 0;
        blk_bytes        = '0;
        start_new_message();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_message();
        test_short_messages();
        test_pad_boundaries();
        test_back_pressure();
        test_steady_stream();
        test_random_messages();

        // drain and let the block settle
        sender_quiet();
        wait_drained();
        repeat (END_SETTLE) @(posedge clk);

        $display("Sent %0d request beats and checked %0d digests: empty, short,",
                 beats_sent, digests_checked);
        $display("pad-boundary and multi-block messages, a long digest stall, idle gaps.");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sha256_byte_stream_hasher.f
rtl/s256_pkg.sv
rtl/s256_req_if.sv
rtl/s256_dig_if.sv
rtl/s256_round_core.sv
rtl/sha256_byte_stream_hasher.sv
bench/tb_sha256_byte_stream_hasher.sv
